// ===== hw/rtl/ffskt_pkg.sv =====
// Shared types for the first-free-slot key table: command and status codes,
// request and result beats, and the controller/datapath command and status groups.
// No dependencies.
package ffskt_pkg;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] key_word;
		logic [31:0] value_word;
	} req_t;

	typedef struct packed {
		status_t status;
		logic    full_flag;
		logic    empty_flag;
	} result_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    clear_wr;
		logic    load;
		logic    rd_en;
		logic    commit;
		logic    respond;
		status_t status;
	} ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;
		logic rd_last;
		logic hit;
		logic scan_last;
		logic is_insert;
		logic full;
		logic empty;
	} stat_t;

endpackage

// ===== hw/rtl/ffskt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffskt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/ffskt_datapath.sv =====
// Datapath of the key table: request register, slot address counter, key and
// value RAMs, scan compare, used-slot count and result register.
// Depends on ffskt_pkg and ffskt_ram.
module ffskt_datapath #(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffskt_pkg::req_t   req,
	input  ffskt_pkg::ctl_t   ctl,
	output ffskt_pkg::stat_t  st,
	output ffskt_pkg::result_t result,
	output logic              strobe
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

	ffskt_pkg::req_t req_q;
	logic [AW-1:0]   addr_q;
	logic [AW-1:0]   addr_s1;
	logic            pend_s1;
	logic [CW-1:0]   count_q;
	logic [31:0]     key_rdata;
	logic            key_we;
	logic [AW-1:0]   wr_addr;
	logic [31:0]     key_wdata;
	logic [31:0]     value_wdata;
	logic            is_insert;
	logic            match;

	assign is_insert = (req_q.cmd == ffskt_pkg::CMD_INSERT);

	// Insert looks for a free slot, delete for the given key
	assign match = is_insert ? (key_rdata == 32'd0) : (key_rdata == req_q.key_word);

	assign key_we      = ctl.clear_wr | ctl.commit;
	assign wr_addr     = ctl.clear_wr ? addr_q : addr_s1;
	assign key_wdata   = (ctl.commit && is_insert) ? req_q.key_word : 32'd0;
	assign value_wdata = (ctl.commit && is_insert) ? req_q.value_word : 32'd0;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		addr_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			pend_s1 <= 1'b0;
			count_q <= '0;
			strobe  <= 1'b0;
			result  <= '0;
		end else begin
			pend_s1 <= ctl.rd_en;
			if (ctl.load) begin
				addr_q <= '0;
			end else if (ctl.clear_wr || ctl.rd_en) begin
				addr_q <= addr_q + AW'(1);
			end
			// A zero key never changes the number of slots in use
			if (ctl.commit && req_q.key_word != 32'd0) begin
				if (is_insert) begin
					count_q <= count_q + CW'(1);
				end else begin
					count_q <= count_q - CW'(1);
				end
			end
			strobe <= ctl.respond;
			if (ctl.respond) begin
				result.status     <= ctl.status;
				result.full_flag  <= (count_q == CW'(ENTRIES));
				result.empty_flag <= (count_q == '0);
			end
		end
	end

	ffskt_ram #(
		.WIDTH(32),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(wr_addr),
		.wdata(key_wdata),
		.re   (ctl.rd_en),
		.raddr(addr_q),
		.rdata(key_rdata)
	);

	ffskt_ram #(
		.WIDTH(32),
		.DEPTH(ENTRIES)
	) u_value_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(wr_addr),
		.wdata(value_wdata),
		.re   (1'b0),
		.raddr(addr_q),
		.rdata()
	);

	assign st.clear_last = (addr_q == LAST_ADDR);
	assign st.rd_last    = (addr_q == LAST_ADDR);
	assign st.hit        = pend_s1 & match;
	assign st.scan_last  = pend_s1 & (addr_s1 == LAST_ADDR);
	assign st.is_insert  = is_insert;
	assign st.full       = (count_q == CW'(ENTRIES));
	assign st.empty      = (count_q == '0);

endmodule

// ===== hw/rtl/ffskt_ctrl.sv =====
// Controller of the key table: clearing pass, command check, slot scan and
// response sequencing.
// Depends on ffskt_pkg.
module ffskt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ffskt_pkg::stat_t st,
	output ffskt_pkg::ctl_t  ctl,
	output logic             busy
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_RESP
	} state_t;

	state_t             state_q;
	logic               issue_q;
	ffskt_pkg::status_t status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			issue_q  <= 1'b0;
			status_q <= ffskt_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (st.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (st.is_insert && st.full) begin
						status_q <= ffskt_pkg::ST_FULL;
						state_q  <= S_RESP;
					end else if (!st.is_insert && st.empty) begin
						status_q <= ffskt_pkg::ST_EMPTY;
						state_q  <= S_RESP;
					end else begin
						issue_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (st.hit) begin
						issue_q  <= 1'b0;
						status_q <= ffskt_pkg::ST_OK;
						state_q  <= S_RESP;
					end else if (st.scan_last) begin
						issue_q  <= 1'b0;
						status_q <= ffskt_pkg::ST_NOT_FOUND;
						state_q  <= S_RESP;
					end else if (issue_q && st.rd_last) begin
						// stop issuing reads once the last slot has gone out
						issue_q <= 1'b0;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ctl.clear_wr = (state_q == S_CLEAR);
	assign ctl.load     = (state_q == S_IDLE) && start;
	assign ctl.rd_en    = (state_q == S_SCAN) && issue_q;
	assign ctl.commit   = (state_q == S_SCAN) && st.hit;
	assign ctl.respond  = (state_q == S_RESP);
	assign ctl.status   = status_q;
	assign busy         = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/first_free_slot_key_table_top.sv =====
// Top level of the first-free-slot key table.
// Depends on ffskt_pkg, ffskt_ctrl and ffskt_datapath.
//
// Usage:
//   Request channel: drive req (cmd, key_word, value_word) and raise start;
//   the beat is taken at a rising edge where start is high and busy is low.
//   Insert puts the pair into the lowest free slot (key zero), delete clears
//   the lowest slot holding the key. No duplicate check is made on insert.
//   Result channel: one beat per request, shown on result for exactly one
//   cycle with strobe high. The receiver cannot stall; it must take it.
//   Sequencing: a rejected request (insert on full, delete on empty) goes from
//   the check state straight to the response state. Otherwise the key RAM is
//   read one slot per cycle, from slot 0 up to the first hit or the last slot,
//   and the response follows the scan. busy drops in the same cycle that
//   strobe rises, so a new request is taken only once the last one's result
//   is out.
//   Reset: arst_n clears control state, then a clearing pass writes zero to
//   every slot, one slot a cycle; busy is high meanwhile.
module first_free_slot_key_table_top #(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ffskt_pkg::req_t    req,
	output ffskt_pkg::result_t result,
	output logic               strobe
);

	ffskt_pkg::ctl_t  ctl;
	ffskt_pkg::stat_t st;

	ffskt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.ctl   (ctl),
		.busy  (busy)
	);

	ffskt_datapath #(
		.ENTRIES(ENTRIES)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.ctl   (ctl),
		.st    (st),
		.result(result),
		.strobe(strobe)
	);

endmodule

// ===== tb/sv/first_free_slot_key_table_top_test.sv =====
// Self-checking testbench for the first-free-slot key table top level.
// Depends on ffskt_pkg and the first_free_slot_key_table_top RTL; predicts each
// result from its own copy of the key and value slots.
module first_free_slot_key_table_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES       = 16;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = ENTRIES + 10;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	ffskt_pkg::req_t    req;
	ffskt_pkg::result_t result;
	logic               strobe;

	first_free_slot_key_table_top #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.result (result),
		.strobe (strobe)
	);

	// Predicted table contents
	logic [31:0] key_slots   [ENTRIES];
	logic [31:0] value_slots [ENTRIES];

	ffskt_pkg::result_t pending_results[$];
	logic [31:0]        key_pool[8];
	bit                 draining;
	int                 errors;
	int                 n_items;
	int                 n_results;
	int                 n_full_rej;
	int                 n_empty_rej;
	int                 n_not_found;
	int                 idle_cycles = 0;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic int used_slots();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (key_slots[i] != 32'd0) n++;
		return n;
	endfunction

	function automatic ffskt_pkg::result_t predict_table_op(input ffskt_pkg::req_t item);
		ffskt_pkg::result_t r;
		int                 slot;
		slot = -1;
		r.status = ffskt_pkg::ST_OK;
		if (item.cmd == ffskt_pkg::CMD_INSERT) begin
			for (int i = 0; i < ENTRIES && slot < 0; i++)
				if (key_slots[i] == 32'd0) slot = i;
			if (slot < 0) begin
				r.status = ffskt_pkg::ST_FULL;
			end else begin
				key_slots[slot]   = item.key_word;
				value_slots[slot] = item.value_word;
			end
		end else if (used_slots() == 0) begin
			r.status = ffskt_pkg::ST_EMPTY;
		end else begin
			// A zero key matches the lowest free slot
			for (int i = 0; i < ENTRIES && slot < 0; i++)
				if (key_slots[i] == item.key_word) slot = i;
			if (slot < 0) begin
				r.status = ffskt_pkg::ST_NOT_FOUND;
			end else begin
				key_slots[slot]   = 32'd0;
				value_slots[slot] = 32'd0;
			end
		end
		r.full_flag  = (used_slots() == ENTRIES);
		r.empty_flag = (used_slots() == 0);
		return r;
	endfunction

	function automatic logic [31:0] nonzero_word();
		logic [31:0] w;
		do w = $urandom; while (w == 32'd0);
		return w;
	endfunction

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 32'd0;
		if (r < 50) return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// Key of a randomly chosen occupied slot, or any key if none is occupied
	function automatic logic [31:0] stored_key();
		int idx[$];
		for (int i = 0; i < ENTRIES; i++)
			if (key_slots[i] != 32'd0) idx.push_back(i);
		if (idx.size() == 0) return pick_key();
		return key_slots[idx[$urandom_range(0, idx.size() - 1)]];
	endfunction

	function automatic ffskt_pkg::req_t random_op();
		ffskt_pkg::req_t item;
		int              r;
		if (used_slots() == ENTRIES) draining = 1'b1;
		if (used_slots() == 0) draining = 1'b0;
		item.value_word = $urandom;
		r = $urandom_range(0, 99);
		item.cmd = ((r < 80) == draining) ? ffskt_pkg::CMD_DELETE : ffskt_pkg::CMD_INSERT;
		if (item.cmd == ffskt_pkg::CMD_INSERT) begin
			item.key_word = pick_key();
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) item.key_word = stored_key();
			else if (r < 75) item.key_word = 32'd0;
			else item.key_word = pick_key();
		end
		return item;
	endfunction

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Present one beat, hold it until taken, then idle for the gap given, if any
	task automatic send_beat(input ffskt_pkg::req_t item, input int gap);
		@(negedge clk);
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(predict_table_op(item));
		n_items++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_op(input ffskt_pkg::cmd_t cmd, input logic [31:0] k,
		input logic [31:0] v);
		ffskt_pkg::req_t item;
		item.cmd        = cmd;
		item.key_word   = k;
		item.value_word = v;
		send_beat(item, random_gap());
	endtask

	always @(posedge clk) begin
		ffskt_pkg::result_t exp_res;
		if (arst_n && strobe === 1'b1) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result beat with no prediction waiting");
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (result.status !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, result.status);
					errors++;
				end
				if (result.full_flag !== exp_res.full_flag) begin
					$error("full_flag: expected %0b, got %0b",
						exp_res.full_flag, result.full_flag);
					errors++;
				end
				if (result.empty_flag !== exp_res.empty_flag) begin
					$error("empty_flag: expected %0b, got %0b",
						exp_res.empty_flag, result.empty_flag);
					errors++;
				end
				case (exp_res.status)
					ffskt_pkg::ST_FULL:      n_full_rej++;
					ffskt_pkg::ST_EMPTY:     n_empty_rej++;
					ffskt_pkg::ST_NOT_FOUND: n_not_found++;
					default: ;
				endcase
			end
		end
	end

	// Count cycles in which no beat moves in either direction
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_directed_corners();
		logic [31:0] last_key;
		last_key = 32'd0;
		send_op(ffskt_pkg::CMD_DELETE, 32'd0, 32'hFFFF_FFFF);
		// Zero key goes in but the slot stays free
		send_op(ffskt_pkg::CMD_INSERT, 32'd0, 32'hFFFF_FFFF);
		send_op(ffskt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'd0);
		send_op(ffskt_pkg::CMD_INSERT, 32'h0000_0001, 32'hFFFF_FFFF);
		send_op(ffskt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
		send_op(ffskt_pkg::CMD_DELETE, 32'hDEAD_BEEF, 32'd0);
		send_op(ffskt_pkg::CMD_DELETE, 32'd0, 32'd0);
		send_op(ffskt_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		while (used_slots() < ENTRIES) begin
			last_key = nonzero_word();
			send_op(ffskt_pkg::CMD_INSERT, last_key, $urandom);
		end
		send_op(ffskt_pkg::CMD_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		send_op(ffskt_pkg::CMD_DELETE, 32'd0, 32'd0);
		send_op(ffskt_pkg::CMD_DELETE, last_key, 32'd0);
	endtask

	task automatic test_random_fill_drain(input int count);
		for (int i = 0; i < count; i++)
			send_beat(random_op(), random_gap());
	endtask

	task automatic test_back_to_back(input int count);
		for (int i = 0; i < count; i++)
			send_beat(random_op(), 0);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		draining    = 1'b0;
		errors      = 0;
		n_items     = 0;
		n_results   = 0;
		n_full_rej  = 0;
		n_empty_rej = 0;
		n_not_found = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			key_slots[i]   = 32'd0;
			value_slots[i] = 32'd0;
		end
		for (int i = 0; i < 8; i++)
			key_pool[i] = nonzero_word();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed_corners();
		test_random_fill_drain(1025);
		test_back_to_back(500);
		wait_for_drain();

		if (pending_results.size() != 0) begin
			$error("%0d predicted results never arrived", pending_results.size());
			errors++;
		end
		$display("Covered %0d operations and %0d results through repeated fill and drain.",
			n_items, n_results);
		$display("Rejections seen: %0d full, %0d empty, %0d not found; %0d mismatches.",
			n_full_rej, n_empty_rej, n_not_found, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ffskt_pkg.sv
hw/rtl/ffskt_ram.sv
hw/rtl/ffskt_datapath.sv
hw/rtl/ffskt_ctrl.sv
hw/rtl/first_free_slot_key_table_top.sv
tb/sv/first_free_slot_key_table_top_test.sv
